FILE: rtl/rem_pkg.sv
// Package for the regression error metrics block: field widths, constants,
// state and phase codes, and the command/status/result structs.
// No dependencies.
package rem_pkg;

    localparam int SAMP_W    = 24;
    localparam int ERR_W     = 25;
    localparam int SQ_W      = 62;
    localparam int ABS_W     = 37;
    localparam int ACT_W     = 37;
    localparam int ASQ_W     = 59;
    localparam int MSE_W     = 50;
    localparam int R2_W      = 32;
    localparam int FC_W      = 8;
    localparam int THR_W     = 40;
    localparam int CNT_OUT_W = 13;
    localparam int CFG_IDX_W = 8;
    localparam int CFG_DAT_W = 40;

    localparam int PROD_W    = 2 * ACT_W;
    localparam int NUM_W     = SQ_W + 24;
    localparam int DEN_W     = ASQ_W;
    localparam int STEP_W    = 7;

    localparam logic [STEP_W-1:0] MUL_STEPS  = 7'd37;
    localparam logic [STEP_W-1:0] DIV_STEPS  = 7'd86;
    localparam logic [STEP_W-1:0] ROOT_STEPS = 7'd25;

    localparam logic signed [R2_W-1:0] R2_ONE = 32'sh0100_0000;
    localparam logic signed [R2_W-1:0] R2_MIN = 32'sh8000_0000;
    localparam logic [NUM_W-1:0] Q_LIMIT = NUM_W'(64'h0000_0000_8100_0000);

    localparam logic [CFG_IDX_W-1:0] CFG_FEATURES  = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 8'd1;

    typedef enum logic [3:0] {
        ST_IDLE, ST_MUL, ST_CORR, ST_MSE, ST_MAE, ST_ROOT, ST_R2, ST_ADJM, ST_ADJ, ST_SEND
    } state_t;

    typedef enum logic [2:0] {
        PH_MUL, PH_CORR, PH_MSE, PH_MAE, PH_ROOT, PH_R2, PH_ADJM, PH_ADJ
    } phase_t;

    typedef struct packed {
        logic   fold;
        logic   start;
        phase_t phase;
        logic   clear;
    } cmd_t;

    typedef struct packed {
        logic done;
    } stat_t;

    typedef struct packed {
        logic [SQ_W-1:0]      sum_sq_error;
        logic [ASQ_W-1:0]     total_sum_sq;
        logic [MSE_W-1:0]     mean_sq_error;
        logic [ERR_W-1:0]     mean_abs_error;
        logic [ERR_W-1:0]     root_mean_sq_error;
        logic [ERR_W-1:0]     max_abs_error;
        logic signed [R2_W-1:0] r_squared;
        logic signed [R2_W-1:0] adjusted_r_squared;
        logic                 adjusted_valid;
        logic [CNT_OUT_W-1:0] sample_count;
        logic                 overflowed;
    } res_t;

endpackage

FILE: rtl/rem_if.sv
// Channel interfaces for the regression error metrics block.
// Depends on rem_pkg for field widths.
interface rem_pair_if;
    logic                                valid;
    logic                                ready;
    logic signed [rem_pkg::SAMP_W-1:0]   actual;
    logic signed [rem_pkg::SAMP_W-1:0]   predicted;
    logic                                last;

    modport source (output valid, actual, predicted, last, input ready);
    modport sink   (input valid, actual, predicted, last, output ready);
endinterface

interface rem_metrics_if;
    logic                                 valid;
    logic                                 ready;
    logic [rem_pkg::SQ_W-1:0]             sum_sq_error;
    logic [rem_pkg::ASQ_W-1:0]            total_sum_sq;
    logic [rem_pkg::MSE_W-1:0]            mean_sq_error;
    logic [rem_pkg::ERR_W-1:0]            mean_abs_error;
    logic [rem_pkg::ERR_W-1:0]            root_mean_sq_error;
    logic [rem_pkg::ERR_W-1:0]            max_abs_error;
    logic signed [rem_pkg::R2_W-1:0]      r_squared;
    logic signed [rem_pkg::R2_W-1:0]      adjusted_r_squared;
    logic                                 adjusted_valid;
    logic [rem_pkg::CNT_OUT_W-1:0]        sample_count;
    logic                                 overflowed;

    modport source (output valid, sum_sq_error, total_sum_sq, mean_sq_error, mean_abs_error,
                    root_mean_sq_error, max_abs_error, r_squared, adjusted_r_squared,
                    adjusted_valid, sample_count, overflowed, input ready);
    modport sink   (input valid, sum_sq_error, total_sum_sq, mean_sq_error, mean_abs_error,
                    root_mean_sq_error, max_abs_error, r_squared, adjusted_r_squared,
                    adjusted_valid, sample_count, overflowed, output ready);
endinterface

FILE: rtl/rem_ctrl.sv
// Controller for the regression error metrics block: sequences the fold,
// the final multiplies, divides and root, and the result handshake.
// Depends on rem_pkg.
module rem_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    input  logic           in_last,
    output logic           in_ready,
    output logic           out_valid,
    input  logic           out_ready,
    input  rem_pkg::stat_t stat,
    output rem_pkg::cmd_t  cmd
);
    import rem_pkg::*;

    state_t state_reg, state_next;
    logic   go_reg, go_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            go_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            go_reg    <= go_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: if (in_valid && in_last) state_next = ST_MUL;
            ST_MUL:  if (stat.done) state_next = ST_CORR;
            ST_CORR: if (stat.done) state_next = ST_MSE;
            ST_MSE:  if (stat.done) state_next = ST_MAE;
            ST_MAE:  if (stat.done) state_next = ST_ROOT;
            ST_ROOT: if (stat.done) state_next = ST_R2;
            ST_R2:   if (stat.done) state_next = ST_ADJM;
            ST_ADJM: if (stat.done) state_next = ST_ADJ;
            ST_ADJ:  if (stat.done) state_next = ST_SEND;
            ST_SEND: if (out_ready) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
        go_next = (state_next != state_reg) && (state_next != ST_IDLE)
                  && (state_next != ST_SEND);
    end

    always_comb
    begin
        in_ready  = (state_reg == ST_IDLE);
        out_valid = (state_reg == ST_SEND);
        cmd.fold  = (state_reg == ST_IDLE) && in_valid;
        cmd.start = go_reg;
        cmd.clear = (state_reg == ST_SEND) && out_ready;
        case (state_reg)
            ST_MUL:  cmd.phase = PH_MUL;
            ST_CORR: cmd.phase = PH_CORR;
            ST_MSE:  cmd.phase = PH_MSE;
            ST_MAE:  cmd.phase = PH_MAE;
            ST_ROOT: cmd.phase = PH_ROOT;
            ST_R2:   cmd.phase = PH_R2;
            ST_ADJM: cmd.phase = PH_ADJM;
            ST_ADJ:  cmd.phase = PH_ADJ;
            default: cmd.phase = PH_MUL;
        endcase
    end

    a_no_start_on_done: assert property (@(posedge clk) disable iff (!rst_n)
        stat.done |-> !cmd.start) else $error("start issued while unit finishing");
    a_idle_after_send: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready) |=> in_ready) else $error("no return to idle");
    a_no_fold_in_send: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.fold |-> !out_valid) else $error("fold while result pending");
    a_start_after_move: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.start |-> !$stable(state_reg)) else $error("start without phase change");

endmodule

FILE: rtl/rem_dp.sv
// Datapath for the regression error metrics block: running totals, config
// registers, a bit-serial multiplier, a restoring divider and a square root.
// Depends on rem_pkg.
module rem_dp #(
    parameter int MAX_ITEMS = 4096
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [rem_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [rem_pkg::CFG_DAT_W-1:0]    cfg_data,
    input  logic signed [rem_pkg::SAMP_W-1:0] actual,
    input  logic signed [rem_pkg::SAMP_W-1:0] predicted,
    input  rem_pkg::cmd_t                    cmd,
    output rem_pkg::stat_t                   stat,
    output rem_pkg::res_t                    res
);
    import rem_pkg::*;

    localparam int CNT_W = $clog2(MAX_ITEMS + 1);
    localparam int D_W   = ((CNT_W > FC_W) ? CNT_W : FC_W) + 2;
    localparam int AP_W  = 33 + CNT_W;

    logic [FC_W-1:0]          feat_reg;
    logic [THR_W-1:0]         thr_reg;
    logic [SQ_W-1:0]          acc_sq_reg;
    logic [ABS_W-1:0]         acc_abs_reg;
    logic [ERR_W-1:0]         peak_reg;
    logic signed [ACT_W-1:0]  acc_act_reg;
    logic [ASQ_W-1:0]         acc_asq_reg;
    logic [CNT_W-1:0]         cnt_reg;
    logic                     ovf_reg;

    logic signed [ERR_W-1:0]  err;
    logic [ERR_W-1:0]         abs_err;
    logic [SAMP_W-1:0]        abs_act;
    logic [2*ERR_W-1:0]       err_sq;
    logic [2*SAMP_W-1:0]      act_sq;
    logic [SQ_W:0]            sq_sum;
    logic [ABS_W:0]           abs_sum;
    logic signed [ACT_W:0]    act_sum;
    logic [ASQ_W:0]           asq_sum;

    always_comb
    begin
        err     = ERR_W'(actual) - ERR_W'(predicted);
        abs_err = err[ERR_W-1] ? ERR_W'(-err) : ERR_W'(err);
        abs_act = actual[SAMP_W-1] ? SAMP_W'(-actual) : SAMP_W'(actual);
        err_sq  = abs_err * abs_err;
        act_sq  = abs_act * abs_act;
        sq_sum  = {1'b0, acc_sq_reg} + (SQ_W+1)'(err_sq);
        abs_sum = {1'b0, acc_abs_reg} + (ABS_W+1)'(abs_err);
        act_sum = (ACT_W+1)'(acc_act_reg) + (ACT_W+1)'(actual);
        asq_sum = {1'b0, acc_asq_reg} + (ASQ_W+1)'(act_sq);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            feat_reg <= FC_W'(1);
            thr_reg  <= THR_W'(1);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_FEATURES:  feat_reg <= cfg_data[FC_W-1:0];
                CFG_THRESHOLD: thr_reg  <= cfg_data[THR_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_sq_reg  <= '0;
            acc_abs_reg <= '0;
            peak_reg    <= '0;
            acc_act_reg <= '0;
            acc_asq_reg <= '0;
            cnt_reg     <= '0;
            ovf_reg     <= 1'b0;
        end
        else if (cmd.clear)
        begin
            acc_sq_reg  <= '0;
            acc_abs_reg <= '0;
            peak_reg    <= '0;
            acc_act_reg <= '0;
            acc_asq_reg <= '0;
            cnt_reg     <= '0;
            ovf_reg     <= 1'b0;
        end
        else if (cmd.fold)
        begin
            if (cnt_reg < CNT_W'(MAX_ITEMS))
            begin
                acc_sq_reg  <= sq_sum[SQ_W] ? '1 : sq_sum[SQ_W-1:0];
                acc_abs_reg <= abs_sum[ABS_W] ? '1 : abs_sum[ABS_W-1:0];
                if (abs_err > peak_reg)
                    peak_reg <= abs_err;
                if (act_sum[ACT_W] != act_sum[ACT_W-1])
                    acc_act_reg <= act_sum[ACT_W] ? {1'b1, {(ACT_W-1){1'b0}}}
                                                  : {1'b0, {(ACT_W-1){1'b1}}};
                else
                    acc_act_reg <= act_sum[ACT_W-1:0];
                acc_asq_reg <= asq_sum[ASQ_W] ? '1 : asq_sum[ASQ_W-1:0];
                cnt_reg     <= cnt_reg + CNT_W'(1);
            end
            else
                ovf_reg <= 1'b1;
        end
    end

    // final arithmetic
    logic [CNT_W-1:0]         n_val;
    logic [ACT_W-1:0]         sum_mag;
    logic signed [D_W-1:0]    dof;
    logic                     adj_ok;
    logic signed [33:0]       one_minus;

    logic [STEP_W-1:0]        step_reg;
    logic                     busy_reg;
    logic [PROD_W:0]          pm_reg;
    logic [ACT_W-1:0]         mcand_reg;
    logic [NUM_W-1:0]         num_reg;
    logic [DEN_W-1:0]         den_reg;
    logic [DEN_W-1:0]         rem_reg;
    logic [MSE_W-1:0]         src_reg;
    logic [ERR_W:0]           rrem_reg;
    logic [ERR_W-1:0]         root_reg;
    logic [AP_W-1:0]          adj_prod_reg;

    logic [ASQ_W-1:0]         sst_reg;
    logic [MSE_W-1:0]         mse_reg;
    logic [ERR_W-1:0]         mae_reg;
    logic [ERR_W-1:0]         rmse_reg;
    logic signed [R2_W-1:0]   r2_reg;
    logic signed [R2_W-1:0]   adj_reg;

    logic [ACT_W:0]           m_sum;
    logic [DEN_W:0]           d_sh;
    logic                     d_ge;
    logic [ERR_W+2:0]         r_sh;
    logic [ERR_W+2:0]         r_trial;
    logic                     r_ge;
    logic                     flat;
    logic signed [R2_W-1:0]   q_r2;

    always_comb
    begin
        n_val     = (cnt_reg == '0) ? CNT_W'(1) : cnt_reg;
        sum_mag   = acc_act_reg[ACT_W-1] ? ACT_W'(-acc_act_reg) : ACT_W'(acc_act_reg);
        dof       = D_W'(n_val) - D_W'(feat_reg) - D_W'(1);
        adj_ok    = (dof > 0);
        one_minus = 34'(R2_ONE) - 34'(r2_reg);
        m_sum     = {1'b0, pm_reg[PROD_W-1:ACT_W]} + (ACT_W+1)'(pm_reg[0] ? mcand_reg : '0);
        d_sh      = {rem_reg, num_reg[NUM_W-1]};
        d_ge      = d_sh >= {1'b0, den_reg};
        r_sh      = {rrem_reg, src_reg[MSE_W-1:MSE_W-2]};
        r_trial   = {1'b0, root_reg, 2'b01};
        r_ge      = r_sh >= r_trial;
        flat      = (sst_reg < ASQ_W'(thr_reg)) || (sst_reg == '0);
        q_r2      = (num_reg >= Q_LIMIT) ? R2_MIN : R2_ONE - $signed(num_reg[R2_W-1:0]);
        stat.done = busy_reg && (step_reg == '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            step_reg <= '0;
        end
        else if (cmd.start)
        begin
            busy_reg <= 1'b1;
            case (cmd.phase)
                PH_MUL:  step_reg <= MUL_STEPS;
                PH_ROOT: step_reg <= ROOT_STEPS;
                PH_ADJM: step_reg <= '0;
                default: step_reg <= DIV_STEPS;
            endcase
        end
        else if (busy_reg)
        begin
            if (step_reg == '0)
                busy_reg <= 1'b0;
            else
                step_reg <= step_reg - STEP_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            rem_reg <= '0;
            case (cmd.phase)
                PH_MUL:
                begin
                    pm_reg    <= (PROD_W+1)'(sum_mag);
                    mcand_reg <= sum_mag;
                end
                PH_CORR:
                begin
                    num_reg <= NUM_W'(pm_reg[PROD_W-1:0]);
                    den_reg <= DEN_W'(n_val);
                end
                PH_MSE:
                begin
                    num_reg <= NUM_W'(acc_sq_reg);
                    den_reg <= DEN_W'(n_val);
                end
                PH_MAE:
                begin
                    num_reg <= NUM_W'(acc_abs_reg);
                    den_reg <= DEN_W'(n_val);
                end
                PH_ROOT:
                begin
                    src_reg  <= mse_reg;
                    rrem_reg <= '0;
                    root_reg <= '0;
                end
                PH_R2:
                begin
                    num_reg <= {acc_sq_reg, 24'b0};
                    den_reg <= sst_reg;
                end
                PH_ADJM:
                    adj_prod_reg <= AP_W'(one_minus[32:0]) * AP_W'(n_val - CNT_W'(1));
                PH_ADJ:
                begin
                    num_reg <= NUM_W'(adj_prod_reg);
                    den_reg <= DEN_W'(dof);
                end
                default: ;
            endcase
        end
        else if (busy_reg && step_reg != '0)
        begin
            case (cmd.phase)
                PH_MUL:
                    pm_reg <= {1'b0, m_sum, pm_reg[ACT_W-1:1]};
                PH_ROOT:
                begin
                    src_reg  <= {src_reg[MSE_W-3:0], 2'b00};
                    rrem_reg <= r_ge ? (ERR_W+1)'(r_sh - r_trial) : (ERR_W+1)'(r_sh);
                    root_reg <= {root_reg[ERR_W-2:0], r_ge};
                end
                PH_ADJM: ;
                default:
                begin
                    rem_reg <= d_ge ? DEN_W'(d_sh - {1'b0, den_reg}) : DEN_W'(d_sh);
                    num_reg <= {num_reg[NUM_W-2:0], d_ge};
                end
            endcase
        end
        else if (stat.done)
        begin
            case (cmd.phase)
                PH_CORR:
                    sst_reg <= (NUM_W'(acc_asq_reg) >= num_reg)
                               ? acc_asq_reg - num_reg[ASQ_W-1:0] : '0;
                PH_MSE:
                    mse_reg <= (|num_reg[NUM_W-1:MSE_W]) ? '1 : num_reg[MSE_W-1:0];
                PH_MAE:
                    mae_reg <= (|num_reg[NUM_W-1:ERR_W]) ? '1 : num_reg[ERR_W-1:0];
                PH_ROOT:
                    rmse_reg <= root_reg;
                PH_R2:
                    r2_reg <= flat ? R2_ONE : q_r2;
                PH_ADJ:
                    adj_reg <= adj_ok ? q_r2 : '0;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        res.sum_sq_error       = acc_sq_reg;
        res.total_sum_sq       = sst_reg;
        res.mean_sq_error      = mse_reg;
        res.mean_abs_error     = mae_reg;
        res.root_mean_sq_error = rmse_reg;
        res.max_abs_error      = peak_reg;
        res.r_squared          = r2_reg;
        res.adjusted_r_squared = adj_reg;
        res.adjusted_valid     = adj_ok;
        res.sample_count       = CNT_OUT_W'(cnt_reg);
        res.overflowed         = ovf_reg;
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(MAX_ITEMS)) else $error("pair count past limit");
    a_peak_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.fold |=> peak_reg >= $past(peak_reg) || $past(cmd.clear))
        else $error("peak error decreased");
    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.start |-> !busy_reg) else $error("unit restarted while busy");

endmodule

FILE: rtl/regression_error_metrics.sv
// Regression error metrics over a data set of (actual, predicted) pairs.
// Channel "pairs" takes one word per pair: actual and predicted (signed
// Q12.12) and last. Channel "metrics" gives one word per data set: SSE, SST,
// MSE, MAE, RMSE, peak error, R2, adjusted R2, sample count and status flags.
// Configuration: cfg_we/cfg_index/cfg_data; index 0 is the feature count,
// index 1 the flat-data threshold on SST. Write only while idle.
// Throughput: one pair per cycle while a data set streams in; the running
// totals fold each pair in the cycle it is accepted.
// After the last pair the result is computed by a 37-step serial multiply,
// five 86-step restoring divides on one shared divider, a 25-step square
// root and a multiply for adjusted R2. No pair is accepted meanwhile.
// Reset clears all totals, feature count to 1 and threshold to 1.
// A stalled result holds until taken; totals clear on that handshake and
// the block takes pairs again in the next cycle.
// Depends on rem_pkg, rem_if, rem_ctrl and rem_dp.
module regression_error_metrics #(
    parameter int MAX_ITEMS = 4096
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [rem_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [rem_pkg::CFG_DAT_W-1:0]  cfg_data,
    rem_pair_if.sink                       pairs,
    rem_metrics_if.source                  metrics
);
    import rem_pkg::*;

    cmd_t  cmd;
    stat_t stat;
    res_t  res;
    logic  in_ready;
    logic  out_valid;

    rem_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (pairs.valid),
        .in_last   (pairs.last),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (metrics.ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    rem_dp #(.MAX_ITEMS(MAX_ITEMS)) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .actual    (pairs.actual),
        .predicted (pairs.predicted),
        .cmd       (cmd),
        .stat      (stat),
        .res       (res)
    );

    assign pairs.ready                = in_ready;
    assign metrics.valid              = out_valid;
    assign metrics.sum_sq_error       = res.sum_sq_error;
    assign metrics.total_sum_sq       = res.total_sum_sq;
    assign metrics.mean_sq_error      = res.mean_sq_error;
    assign metrics.mean_abs_error     = res.mean_abs_error;
    assign metrics.root_mean_sq_error = res.root_mean_sq_error;
    assign metrics.max_abs_error      = res.max_abs_error;
    assign metrics.r_squared          = res.r_squared;
    assign metrics.adjusted_r_squared = res.adjusted_r_squared;
    assign metrics.adjusted_valid     = res.adjusted_valid;
    assign metrics.sample_count       = res.sample_count;
    assign metrics.overflowed         = res.overflowed;

endmodule
